[rtl/core/flash_command_queue_sequencer_top_assert.svh]
// assertion macros for the flash command queue sequencer
`ifndef FLASH_COMMAND_QUEUE_SEQUENCER_TOP_ASSERT_SVH
`define FLASH_COMMAND_QUEUE_SEQUENCER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FCQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FCQS_ASSERT_IMP(lbl, ante, cons, msg) \
  `FCQS_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define FCQS_ASSERT(lbl, prop, msg)
`define FCQS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/fcqs_pkg.sv]
// types and constants of the flash command queue sequencer
`timescale 1ns / 1ps
package fcqs_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int MEM_BYTES    = 4194304;
  localparam int SECTOR_COUNT = 8;
  localparam int SECTOR_SHIFT = 16;
  localparam int MAX_TRANSFER = 1024;

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int PTR_W     = IDX_W + 1;
  localparam int LVL_W     = 6;
  localparam int ADDR_W    = 22;
  localparam int SIZE_W    = 16;
  localparam int SECTOR_W  = 16;
  localparam int CSIZE_W   = 11;
  localparam int TO_W      = 24;
  localparam int ELAPSED_W = 25;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USED_W = 3 + ADDR_W + CSIZE_W + 1 + 1 + LVL_W;

  localparam logic [2:0] CFG_ADDR_W = 3'd3;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_TICK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_TICK    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PROG  = 3'd2,
    CMD_ERASE = 3'd3,
    CMD_WDIS  = 3'd4
  } command_e;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_PROG  = 2'd1,
    OP_ERASE = 2'd2,
    OP_WAIT  = 2'd3
  } op_kind_e;

  typedef enum logic {
    REG_PROG_TO  = 1'b0,
    REG_ERASE_TO = 1'b1
  } reg_idx_e;

  // one ring entry: amount is a byte count, or the timeout of a wait op
  typedef struct packed {
    op_kind_e            kind;
    logic [ADDR_W-1:0]   faddr;
    logic [TO_W-1:0]     amount;
    logic                note;
  } ring_entry_t;

  typedef struct packed {
    status_e             status;
    command_e            command;
    logic [ADDR_W-1:0]   cmd_addr;
    logic [CSIZE_W-1:0]  cmd_size;
    logic                read_done;
    logic                timed_out;
    logic [LVL_W-1:0]    queue_level;
  } result_t;

endpackage

[rtl/core/flash_command_queue_sequencer_top.sv]
// flash command queue sequencer: request checks, op ring and tick sequencer
`timescale 1ns / 1ps
`include "flash_command_queue_sequencer_top_assert.svh"
// Takes read, write and erase requests and tick words on one stream and returns one result
// word per input word. Ops live in a ring memory with one write port and a registered
// read, so a read request, a rejected request and a tick that does not take a new op
// have their result loaded from the idle state, while an accepted write or erase request
// (two ring writes through the one write port) and a tick that takes the next op (through
// the registered ring read) go on to S_PUSH2 or S_FETCH first. One word is worked on at
// a time; the next word is taken no earlier than the cycle in which the previous result
// leaves the output register, so a stalled result holds off the input. The timeout
// registers are written over the APB port at byte addresses 0 (program) and 4 (erase).
module flash_command_queue_sequencer_top
  import fcqs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // addr, size, sector, notify, flash_busy
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // command, cmd_addr, cmd_size, read_done, timed_out, queue_level, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]            m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_PUSH2 = 2'd2;

  // input fields
  action_e             in_action;
  logic [ADDR_W-1:0]   in_addr;
  logic [SIZE_W-1:0]   in_size;
  logic [SECTOR_W-1:0] in_sector;
  logic                in_notify;
  logic                in_busy;

  logic [1:0]          state_q, state_d;
  logic [PTR_W-1:0]    rp_q, rp_d, wp_q, wp_d;
  logic                fin_q, fin_d;
  logic [TO_W-1:0]     cur_to_q, cur_to_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                busy_q, busy_d;
  logic                erase_q, erase_d;
  logic [TO_W-1:0]     prog_to_q, erase_to_q;
  logic                m_valid_q, m_valid_d;
  result_t             res_q, res_d;

  logic                s_ready, in_fire, load_out;
  logic [PTR_W-1:0]    lvl;
  logic [ADDR_W:0]     end_addr;
  logic                range_ok, sector_ok, full1, full2;
  logic [ADDR_W-1:0]   erase_addr;
  logic                wait_done, wait_tout;

  ring_entry_t         ring_mem [QUEUE_DEPTH];
  ring_entry_t         rd_data_q, wr_entry;
  logic                wr_en, rd_en;
  logic                cfg_we;

  assign in_action = action_e'(s_axis_tuser);
  assign in_addr   = s_axis_tdata[ADDR_W-1:0];
  assign in_size   = s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W];
  assign in_sector = s_axis_tdata[ADDR_W+SIZE_W+SECTOR_W-1:ADDR_W+SIZE_W];
  assign in_notify = s_axis_tdata[ADDR_W+SIZE_W+SECTOR_W];
  assign in_busy   = s_axis_tdata[ADDR_W+SIZE_W+SECTOR_W+1];

  assign s_ready       = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = s_ready;
  assign in_fire       = s_axis_tvalid && s_ready;

  assign lvl      = wp_q - rp_q;
  assign full1    = (lvl == PTR_W'(QUEUE_DEPTH));
  assign full2    = (lvl >= PTR_W'(QUEUE_DEPTH - 1));
  assign end_addr = {1'b0, in_addr} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, in_size};
  assign range_ok = ({1'b0, in_addr} < (ADDR_W + 1)'(MEM_BYTES))
                 && (in_size <= SIZE_W'(MAX_TRANSFER))
                 && (end_addr <= (ADDR_W + 1)'(MEM_BYTES))
                 && (in_size != '0);
  assign sector_ok  = (in_sector < SECTOR_W'(SECTOR_COUNT));
  assign erase_addr = ADDR_W'({{(32 - SECTOR_W){1'b0}}, in_sector} << SECTOR_SHIFT);

  // running wait op: elapsed time advanced by one, saturating
  always_comb begin
    elapsed_d = elapsed_q;
    if (elapsed_q != '1) begin
      elapsed_d = elapsed_q + ELAPSED_W'(1);
    end
    wait_tout = in_busy && (cur_to_q != '0) && (elapsed_d > {1'b0, cur_to_q});
    wait_done = !in_busy || wait_tout;
  end

  always_comb begin
    state_d  = state_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    fin_d    = fin_q;
    cur_to_d = cur_to_q;
    busy_d   = busy_q;
    erase_d  = erase_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_entry = '{kind: OP_READ, faddr: in_addr, amount: TO_W'(in_size), note: in_notify};
    load_out = 1'b0;
    res_d    = '{status: ST_OK, command: CMD_NONE, cmd_addr: '0, cmd_size: '0,
                 read_done: 1'b0, timed_out: 1'b0, queue_level: '0};
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action) inside
            ACT_READ, ACT_WRITE: begin
              if (!range_ok) begin
                res_d.status = ST_INVALID;
                load_out     = 1'b1;
              end else if ((in_action == ACT_READ) ? full1 : full2) begin
                res_d.status = ST_BUSY;
                load_out     = 1'b1;
              end else begin
                wr_en = 1'b1;
                wp_d  = wp_q + PTR_W'(1);
                if (in_action == ACT_READ) begin
                  load_out = 1'b1;
                end else begin
                  wr_entry.kind = OP_PROG;
                  wr_entry.note = 1'b0;
                  erase_d       = 1'b0;
                  state_d       = S_PUSH2;
                end
              end
            end
            ACT_ERASE: begin
              if (!sector_ok) begin
                res_d.status = ST_INVALID;
                load_out     = 1'b1;
              end else if (full2) begin
                res_d.status = ST_BUSY;
                load_out     = 1'b1;
              end else begin
                wr_en    = 1'b1;
                wr_entry = '{kind: OP_ERASE, faddr: erase_addr, amount: '0, note: 1'b0};
                wp_d     = wp_q + PTR_W'(1);
                erase_d  = 1'b1;
                state_d  = S_PUSH2;
              end
            end
            default: begin
              res_d.status = ST_TICK;
              if (fin_q) begin
                if (lvl == '0) begin
                  load_out = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  rp_d    = rp_q + PTR_W'(1);
                  busy_d  = in_busy;
                  state_d = S_FETCH;
                end
              end else begin
                res_d.command   = wait_done ? CMD_WDIS : CMD_NONE;
                res_d.timed_out = wait_tout;
                fin_d           = wait_done;
                load_out        = 1'b1;
              end
            end
          endcase
        end
      end
      S_PUSH2: begin
        wr_en    = 1'b1;
        wr_entry = '{kind: OP_WAIT, faddr: '0,
                     amount: erase_q ? erase_to_q : prog_to_q, note: 1'b0};
        wp_d     = wp_q + PTR_W'(1);
        load_out = 1'b1;
        state_d  = S_IDLE;
      end
      S_FETCH: begin
        // fetched op runs at elapsed time zero, so a wait op cannot time out here
        res_d.status = ST_TICK;
        case (rd_data_q.kind)
          OP_READ: begin
            res_d.command   = CMD_READ;
            res_d.cmd_addr  = rd_data_q.faddr;
            res_d.cmd_size  = rd_data_q.amount[CSIZE_W-1:0];
            res_d.read_done = rd_data_q.note;
          end
          OP_PROG: begin
            res_d.command  = CMD_PROG;
            res_d.cmd_addr = rd_data_q.faddr;
            res_d.cmd_size = rd_data_q.amount[CSIZE_W-1:0];
          end
          OP_ERASE: begin
            res_d.command  = CMD_ERASE;
            res_d.cmd_addr = rd_data_q.faddr;
          end
          default: begin
            res_d.command = busy_q ? CMD_NONE : CMD_WDIS;
            fin_d         = !busy_q;
            cur_to_d      = rd_data_q.amount;
          end
        endcase
        load_out = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res_d.queue_level = LVL_W'(wp_d - rp_d);
    m_valid_d = m_valid_q && !m_axis_tready;
    if (load_out) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rp_q      <= '0;
      wp_q      <= '0;
      fin_q     <= 1'b1;
      cur_to_q  <= '0;
      elapsed_q <= '0;
      busy_q    <= 1'b0;
      erase_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      fin_q     <= fin_d;
      cur_to_q  <= cur_to_d;
      busy_q    <= busy_d;
      erase_q   <= erase_d;
      m_valid_q <= m_valid_d;
      if (rd_en) begin
        elapsed_q <= '0;
      end else if (in_fire && in_action == ACT_TICK && !fin_q) begin
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= res_d;
    end
  end

  // op ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wp_q[IDX_W-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rp_q[IDX_W-1:0]];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, res_q.queue_level,
                          res_q.timed_out, res_q.read_done, res_q.cmd_size,
                          res_q.cmd_addr, res_q.command};

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_to_q  <= TO_W'(5000);
      erase_to_q <= TO_W'(3000000);
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_PROG_TO:  prog_to_q  <= pwdata[TO_W-1:0];
        REG_ERASE_TO: erase_to_q <= pwdata[TO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_PROG_TO:  prdata = {{(32 - TO_W){1'b0}}, prog_to_q};
      REG_ERASE_TO: prdata = {{(32 - TO_W){1'b0}}, erase_to_q};
      default:      prdata = '0;
    endcase
  end

  `FCQS_ASSERT(a_level_max, (lvl <= PTR_W'(QUEUE_DEPTH)), "queue level above depth")
  `FCQS_ASSERT_IMP(a_no_take_busy, (state_q != S_IDLE), !s_axis_tready, "word taken mid-item")
  `FCQS_ASSERT(a_fetch_result, (state_q == S_FETCH) |=> (state_q == S_IDLE && m_valid_q),
    "fetch did not deliver a result")
  `FCQS_ASSERT(a_idle_tick, (in_fire && in_action == ACT_TICK && fin_q && lvl == '0)
    |=> ($stable(rp_q) && m_valid_q), "idle tick moved the read pointer")

endmodule
